### hw/rtl/pq_adc_pkg.sv
// pq_adc_pkg: field widths, request codes and fsm states shared by the
// product-quantisation distance engine; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pq_adc_pkg;

    localparam int TYPE_W  = 2;
    localparam int CHUNK_W = 6;
    localparam int CENT_W  = 8;
    localparam int DIM_W   = 4;
    localparam int VALUE_W = 16;
    localparam int ENTRY_W = 32;
    localparam int DIST_W  = 38;

    localparam logic [ENTRY_W-1:0] ENTRY_MAX = '1;
    localparam logic [DIST_W-1:0]  DIST_MAX  = '1;

    // request kinds carried in req_type
    typedef enum logic [TYPE_W-1:0] {
        REQ_LOAD  = 2'd0,
        REQ_QUERY = 2'd1,
        REQ_CODE  = 2'd2
    } req_type_t;

    // centroid sweep sequencer
    typedef enum logic [1:0] {
        SW_IDLE,
        SW_SWEEP,
        SW_DRAIN
    } sweep_state_t;

endpackage

`default_nettype wire

### hw/rtl/pq_adc_if.sv
// pq_adc_if: valid/ready channels for requests and distance results
// depends on pq_adc_pkg
`timescale 1ns / 1ps
`default_nettype none

interface pq_adc_req_if import pq_adc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [TYPE_W-1:0]         req_type;
    logic [CHUNK_W-1:0]        chunk_index;
    logic [CENT_W-1:0]         centroid_index;
    logic [DIM_W-1:0]          dim_index;
    logic signed [VALUE_W-1:0] value;
    logic                      last;

    modport source (
        output valid, req_type, chunk_index, centroid_index, dim_index, value, last,
        input  ready
    );
    modport sink (
        input  valid, req_type, chunk_index, centroid_index, dim_index, value, last,
        output ready
    );
endinterface

interface pq_adc_rsp_if import pq_adc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;

    modport source (output valid, distance, input ready);
    modport sink   (input valid, distance, output ready);
endinterface

`default_nettype wire

### hw/rtl/pq_adc_table.sv
// pq_adc_table: distance table memory, one write and one registered read port
// depends on pq_adc_pkg
`timescale 1ns / 1ps
`default_nettype none

module pq_adc_table import pq_adc_pkg::*; #(
    parameter int NUM_CHUNKS    = 48,
    parameter int NUM_CENTROIDS = 256,
    parameter int TBL_AW        = 14
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               we,
    input  wire logic [TBL_AW-1:0]  waddr,
    input  wire logic [ENTRY_W-1:0] wdata,
    input  wire logic               re,
    input  wire logic [TBL_AW-1:0]  raddr,
    output logic [ENTRY_W-1:0]      rdata
);

    localparam int TBL_DEPTH = NUM_CHUNKS * NUM_CENTROIDS;

    logic [ENTRY_W-1:0] tbl_mem [TBL_DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            tbl_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= tbl_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

`ifndef SYNTHESIS
    // the interlock keeps reads off entries whose update is still in flight
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        !(we && re && (waddr == raddr)))
        else $error("table read and write hit the same entry");
`endif

endmodule

`default_nettype wire

### hw/rtl/pq_adc_sweep.sv
// pq_adc_sweep: codebook memory and the centroid sweep that rebuilds one
// chunk of the distance table per query request; depends on pq_adc_pkg
`timescale 1ns / 1ps
`default_nettype none

module pq_adc_sweep import pq_adc_pkg::*; #(
    parameter int NUM_CHUNKS    = 48,
    parameter int NUM_CENTROIDS = 256,
    parameter int SUB_DIM       = 4,
    parameter int TBL_AW        = 14
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // codebook load
    input  wire logic                      load_we,
    input  wire logic [TBL_AW-1:0]         load_tbl,
    input  wire logic [DIM_W-1:0]          load_dim,
    input  wire logic [VALUE_W-1:0]        load_data,
    // query start
    input  wire logic                      start,
    input  wire logic [TBL_AW-1:0]         start_base,
    input  wire logic [DIM_W-1:0]          query_dim,
    input  wire logic signed [VALUE_W-1:0] start_value,
    output logic                           busy,
    // distance table access
    output logic                           tbl_re,
    output logic [TBL_AW-1:0]              tbl_raddr,
    input  wire logic [ENTRY_W-1:0]        tbl_rdata,
    output logic                           tbl_we,
    output logic [TBL_AW-1:0]              tbl_waddr,
    output logic [ENTRY_W-1:0]             tbl_wdata
);

    localparam int CB_DEPTH = NUM_CHUNKS * NUM_CENTROIDS * SUB_DIM;
    localparam int CB_AW    = $clog2(CB_DEPTH);
    localparam int CNT_W    = $clog2(NUM_CENTROIDS);

    logic [VALUE_W-1:0] cb_mem [CB_DEPTH];

    sweep_state_t              state_reg, state_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [TBL_AW-1:0]         base_reg;
    logic [DIM_W-1:0]          dim_reg;
    logic signed [VALUE_W-1:0] qval_reg;
    logic                      first_reg;

    logic                      s1_vld_reg, s2_vld_reg;
    logic [TBL_AW-1:0]         s1_addr_reg, s2_addr_reg;
    logic [VALUE_W-1:0]        cb_rdata_reg;
    logic [ENTRY_W-1:0]        sq_reg, old_reg;

    logic [TBL_AW-1:0]         cur_addr;
    logic [CB_AW-1:0]          cb_raddr, cb_waddr;
    logic signed [VALUE_W:0]   diff;
    logic signed [2*VALUE_W+1:0] prod;
    logic [ENTRY_W:0]          sum;

    assign cur_addr = base_reg + TBL_AW'(cnt_reg);
    assign cb_raddr = CB_AW'(32'(cur_addr) * SUB_DIM + 32'(dim_reg));
    assign cb_waddr = CB_AW'(32'(load_tbl) * SUB_DIM + 32'(load_dim));

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        tbl_re     = 1'b0;
        case (state_reg)
            SW_IDLE:
            begin
                if (start)
                begin
                    state_next = SW_SWEEP;
                    cnt_next   = '0;
                end
            end
            SW_SWEEP:
            begin
                tbl_re   = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NUM_CENTROIDS - 1))
                begin
                    state_next = SW_DRAIN;
                end
            end
            SW_DRAIN:
            begin
                if (!s1_vld_reg && !s2_vld_reg)
                begin
                    state_next = SW_IDLE;
                end
            end
            default:
            begin
                state_next = SW_IDLE;
            end
        endcase
    end

    assign busy      = (state_reg != SW_IDLE);
    assign tbl_raddr = cur_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= SW_IDLE;
            cnt_reg    <= '0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            s1_vld_reg <= tbl_re;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    // query latch and pipeline payload
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            base_reg  <= start_base;
            dim_reg   <= query_dim;
            qval_reg  <= start_value;
            first_reg <= (query_dim == '0);
        end
        s1_addr_reg <= cur_addr;
        s2_addr_reg <= s1_addr_reg;
        sq_reg      <= prod[ENTRY_W-1:0];
        old_reg     <= tbl_rdata;
    end

    // codebook memory
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            cb_mem[cb_waddr] <= load_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_re)
        begin
            cb_rdata_reg <= cb_mem[cb_raddr];
        end
    end

    // squared difference, exact in 32 bits
    assign diff = $signed({qval_reg[VALUE_W-1], qval_reg})
                - $signed({cb_rdata_reg[VALUE_W-1], cb_rdata_reg});
    assign prod = diff * diff;

    // dimension zero restarts the entry, later ones add with saturation
    assign sum       = {1'b0, old_reg} + {1'b0, sq_reg};
    assign tbl_we    = s2_vld_reg;
    assign tbl_waddr = s2_addr_reg;
    assign tbl_wdata = first_reg ? sq_reg : (sum[ENTRY_W] ? ENTRY_MAX : sum[ENTRY_W-1:0]);

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == SW_IDLE))
        else $error("query started while a sweep is running");
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_we |-> busy)
        else $error("table write outside a sweep");
`endif

endmodule

`default_nettype wire

### hw/rtl/pq_adc_accum.sv
// pq_adc_accum: distance accumulator and two-entry result queue
// depends on pq_adc_pkg and pq_adc_if
`timescale 1ns / 1ps
`default_nettype none

module pq_adc_accum import pq_adc_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               code_req,
    input  wire logic               code_hit,
    input  wire logic               code_last,
    input  wire logic [ENTRY_W-1:0] tbl_rdata,
    output logic                    can_take,
    pq_adc_rsp_if.source            rsp
);

    logic              c1_vld_reg, c1_hit_reg, c1_last_reg;
    logic [DIST_W-1:0] acc_reg;
    logic [DIST_W-1:0] q_data_reg [2];
    logic              q_head_reg;
    logic [1:0]        q_cnt_reg;

    logic [DIST_W:0]   sum;
    logic [DIST_W-1:0] acc_sat;
    logic              push, pop;
    logic [2:0]        occ;

    assign sum     = {1'b0, acc_reg} + (c1_hit_reg ? (DIST_W+1)'(tbl_rdata) : '0);
    assign acc_sat = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];

    assign push = c1_vld_reg && c1_last_reg;
    assign pop  = rsp.valid && rsp.ready;

    // room for a result from the next request, counting the one in flight
    assign occ      = {1'b0, q_cnt_reg} + {2'b00, push} - {2'b00, pop};
    assign can_take = (occ < 3'd2);

    assign rsp.valid    = (q_cnt_reg != 2'd0);
    assign rsp.distance = q_data_reg[q_head_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_vld_reg <= 1'b0;
            acc_reg    <= '0;
            q_head_reg <= 1'b0;
            q_cnt_reg  <= 2'd0;
        end
        else
        begin
            c1_vld_reg <= code_req;
            if (c1_vld_reg)
            begin
                acc_reg <= c1_last_reg ? '0 : acc_sat;
            end
            if (pop)
            begin
                q_head_reg <= ~q_head_reg;
            end
            q_cnt_reg <= occ[1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        c1_hit_reg  <= code_hit;
        c1_last_reg <= code_last;
        if (push)
        begin
            q_data_reg[q_head_reg ^ q_cnt_reg[0]] <= acc_sat;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> (q_cnt_reg != 2'd2))
        else $error("result queue overflow");
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (acc_reg == '0))
        else $error("accumulator not cleared after last code");
`endif

endmodule

`default_nettype wire

### hw/rtl/pq_adc_distance_core.sv
// pq_adc_distance_core: top level of the product-quantisation distance engine;
// uses pq_adc_pkg, pq_adc_if, pq_adc_sweep, pq_adc_table and pq_adc_accum
// a last code request's distance is registered in the result queue after the table read
// throughput: loads and code requests one per cycle while the result queue has room;
// an in-range query holds the input while the sweep walks the codebook memory
// reset clears control and the accumulator only; memories are not cleared
`timescale 1ns / 1ps
`default_nettype none

module pq_adc_distance_core import pq_adc_pkg::*; #(
    parameter int NUM_CHUNKS    = 48,
    parameter int NUM_CENTROIDS = 256,
    parameter int SUB_DIM       = 4
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    pq_adc_req_if.sink  req,
    pq_adc_rsp_if.source rsp
);

    localparam int TBL_AW = $clog2(NUM_CHUNKS * NUM_CENTROIDS);

    // request decode
    logic               accept;
    logic               is_load, is_query, is_code;
    logic               chunk_ok, cent_ok, dim_ok;
    logic [TBL_AW-1:0]  req_tbl_addr, req_base;

    // sweep side
    logic               sw_busy, sw_re, sw_we;
    logic [TBL_AW-1:0]  sw_raddr, sw_waddr;
    logic [ENTRY_W-1:0] sw_wdata;

    // shared table read port
    logic               tbl_re;
    logic [TBL_AW-1:0]  tbl_raddr;
    logic [ENTRY_W-1:0] tbl_rdata;

    logic               code_req, code_hit;
    logic               can_take;

    // the input stalls during a sweep and whenever a result could not be queued
    assign req.ready = !sw_busy && can_take;
    assign accept    = req.valid && req.ready;

    assign is_load  = (req.req_type == REQ_LOAD);
    assign is_query = (req.req_type == REQ_QUERY);
    assign is_code  = (req.req_type == REQ_CODE);

    // out-of-range indices: loads and queries are dropped, codes add nothing
    assign chunk_ok = ({1'b0, req.chunk_index} < (CHUNK_W+1)'(NUM_CHUNKS));
    assign cent_ok  = ({1'b0, req.centroid_index} < (CENT_W+1)'(NUM_CENTROIDS));
    assign dim_ok   = ({1'b0, req.dim_index} < (DIM_W+1)'(SUB_DIM));

    // entry of (chunk, centroid) in the table, and the first entry of the chunk
    assign req_tbl_addr = TBL_AW'(32'(req.chunk_index) * NUM_CENTROIDS
                                  + 32'(req.centroid_index));
    assign req_base     = TBL_AW'(32'(req.chunk_index) * NUM_CENTROIDS);

    // code requests look up the table; a last flag on any other kind is ignored
    assign code_req = accept && is_code;
    assign code_hit = chunk_ok && cent_ok;

    // the sweep owns the read port while running, so no request competes for it
    assign tbl_re    = sw_re || (code_req && code_hit);
    assign tbl_raddr = sw_re ? sw_raddr : req_tbl_addr;

    pq_adc_sweep #(
        .NUM_CHUNKS    (NUM_CHUNKS),
        .NUM_CENTROIDS (NUM_CENTROIDS),
        .SUB_DIM       (SUB_DIM),
        .TBL_AW        (TBL_AW)
    ) u_sweep (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_we     (accept && is_load && chunk_ok && cent_ok && dim_ok),
        .load_tbl    (req_tbl_addr),
        .load_dim    (req.dim_index),
        .load_data   (req.value),
        .start       (accept && is_query && chunk_ok && dim_ok),
        .start_base  (req_base),
        .query_dim   (req.dim_index),
        .start_value (req.value),
        .busy        (sw_busy),
        .tbl_re      (sw_re),
        .tbl_raddr   (sw_raddr),
        .tbl_rdata   (tbl_rdata),
        .tbl_we      (sw_we),
        .tbl_waddr   (sw_waddr),
        .tbl_wdata   (sw_wdata)
    );

    pq_adc_table #(
        .NUM_CHUNKS    (NUM_CHUNKS),
        .NUM_CENTROIDS (NUM_CENTROIDS),
        .TBL_AW        (TBL_AW)
    ) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (sw_we),
        .waddr (sw_waddr),
        .wdata (sw_wdata),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    // accumulation in the cycle after the table read, results queued for rsp
    pq_adc_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .code_req  (code_req),
        .code_hit  (code_hit),
        .code_last (req.last),
        .tbl_rdata (tbl_rdata),
        .can_take  (can_take),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

### sim/pq_adc_distance_core_tb.sv
// pq_adc_distance_core_tb: self-checking bench for the pq distance engine with its own
// predictor of codebook store, distance table and accumulator
// depends on pq_adc_pkg, pq_adc_if and pq_adc_distance_core
`timescale 1ns / 1ps

module pq_adc_distance_core_tb;

    import pq_adc_pkg::*;

    localparam int NUM_CHUNKS    = 48;
    localparam int NUM_CENTROIDS = 256;
    localparam int SUB_DIM       = 4;

    // request code the block must ignore
    localparam logic [TYPE_W-1:0] REQ_SPARE = 2'd3;

    // q8.8 extremes
    localparam logic [VALUE_W-1:0] Q_MOST_NEG = 16'h8000;
    localparam logic [VALUE_W-1:0] Q_MOST_POS = 16'h7FFF;

    localparam int RANDOM_ITEMS = 320;
    localparam int CALM_AFTER   = 260;    // no idling from here on
    localparam int SQUEEZE_AT   = 140;    // where the long output hold goes
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = NUM_CENTROIDS + 8;

    // predictor: mirrors the three stores and queues each emitted distance
    class adc_distance_tracker;
        bit [VALUE_W-1:0] centroid_mem [NUM_CHUNKS*NUM_CENTROIDS*SUB_DIM];
        bit [ENTRY_W-1:0] entry_mirror [NUM_CHUNKS*NUM_CENTROIDS];
        bit [DIST_W-1:0]  running_sum;
        bit [DIST_W-1:0]  pending_distances [$];
        int               mismatches;

        function void absorb_request(input logic [TYPE_W-1:0] kind,
                                     input logic [CHUNK_W-1:0] chunk,
                                     input logic [CENT_W-1:0] cent,
                                     input logic [DIM_W-1:0] dim,
                                     input logic signed [VALUE_W-1:0] value,
                                     input logic last);
            int          row;
            int          diff;
            bit [31:0]   mag;
            bit [31:0]   sq;
            bit [32:0]   wide;
            bit [DIST_W:0] acc_wide;
            case (kind)
                REQ_LOAD:
                begin
                    if (chunk < NUM_CHUNKS && cent < NUM_CENTROIDS && dim < SUB_DIM)
                        centroid_mem[(int'(chunk)*NUM_CENTROIDS + int'(cent))*SUB_DIM
                                     + int'(dim)] = value;
                end
                REQ_QUERY:
                begin
                    if (chunk < NUM_CHUNKS && dim < SUB_DIM)
                    begin
                        for (int c = 0; c < NUM_CENTROIDS; c++)
                        begin
                            row  = int'(chunk)*NUM_CENTROIDS + c;
                            diff = int'(value)
                                   - int'($signed(centroid_mem[row*SUB_DIM + int'(dim)]));
                            mag  = (diff < 0) ? -diff : diff;
                            sq   = mag * mag;
                            if (dim == 0)
                                entry_mirror[row] = sq;
                            else
                            begin
                                wide = {1'b0, entry_mirror[row]} + {1'b0, sq};
                                entry_mirror[row] = wide[32] ? ENTRY_MAX : wide[31:0];
                            end
                        end
                    end
                end
                REQ_CODE:
                begin
                    if (chunk < NUM_CHUNKS && cent < NUM_CENTROIDS)
                    begin
                        acc_wide = {1'b0, running_sum}
                                   + (DIST_W+1)'(entry_mirror[int'(chunk)*NUM_CENTROIDS
                                                              + int'(cent)]);
                        running_sum = acc_wide[DIST_W] ? DIST_MAX : acc_wide[DIST_W-1:0];
                    end
                    if (last)
                    begin
                        pending_distances.insert(pending_distances.size(), running_sum);
                        running_sum = '0;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_distance(input logic [DIST_W-1:0] got);
            bit [DIST_W-1:0] want;
            if (pending_distances.size() == 0)
            begin
                if (mismatches < 10)
                    $display("%0t: distance %0d with nothing expected", $realtime, got);
                mismatches++;
            end
            else
            begin
                want = pending_distances.pop_front();
                if (got !== want)
                begin
                    if (mismatches < 10)
                        $display("%0t: distance mismatch, expected %0d got %0d",
                                 $realtime, want, got);
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return pending_distances.size();
        endfunction

        function bit [ENTRY_W-1:0] table_entry(input int chunk, input int cent);
            return entry_mirror[chunk*NUM_CENTROIDS + cent];
        endfunction
    endclass

    logic clk;
    logic rst_n;

    pq_adc_req_if req_ch ();
    pq_adc_rsp_if rsp_ch ();

    pq_adc_distance_core #(
        .NUM_CHUNKS    (NUM_CHUNKS),
        .NUM_CENTROIDS (NUM_CENTROIDS),
        .SUB_DIM       (SUB_DIM)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    adc_distance_tracker tracker = new();

    int real_items;      // accepted requests the block acts on
    bit gaps_on;         // sender idle bursts allowed in this stretch
    bit calm;            // closing stretch, nobody idles
    bit hold_request;    // asks the receiver for one long hold

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // generous ceiling well above the slowest legal run
    initial
    begin
        #20_000_000;
        $display("** pq_adc_distance_core: FAILED **");
        $finish;
    end

    // every accepted request goes through the predictor in order
    always @(posedge clk)
    begin
        if (req_ch.valid && req_ch.ready)
            tracker.absorb_request(req_ch.req_type, req_ch.chunk_index,
                                   req_ch.centroid_index, req_ch.dim_index,
                                   req_ch.value, req_ch.last);
    end

    // every accepted distance is checked against the oldest prediction
    always @(posedge clk)
    begin
        if (rsp_ch.valid && rsp_ch.ready)
            tracker.check_distance(rsp_ch.distance);
    end

    // receiver: short stalls, long ready stretches, and one long hold on demand
    initial
    begin
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                rsp_ch.ready <= 1'b0;
                for (int n = 0; n < LONG_HOLD; n++)
                    @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if ($urandom_range(0, 5) == 0)
                    repeat ($urandom_range(20, 60)) @(posedge clk);
                else
                    repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // one request through the handshake, with an optional idle burst ahead of it
    task automatic send_request(input logic [TYPE_W-1:0] kind, input int chunk,
                                input int cent, input int dim,
                                input logic [VALUE_W-1:0] value, input bit last);
        if (gaps_on && !calm && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.req_type       <= kind;
        req_ch.chunk_index    <= chunk[CHUNK_W-1:0];
        req_ch.centroid_index <= cent[CENT_W-1:0];
        req_ch.dim_index      <= dim[DIM_W-1:0];
        req_ch.value          <= value;
        req_ch.last           <= last;
        do
            @(posedge clk);
        while (!req_ch.ready);
        // ignored requests do not count toward the random budget
        if (!(kind == REQ_SPARE
              || (kind != REQ_CODE && (chunk >= NUM_CHUNKS || dim >= SUB_DIM))))
            real_items++;
    endtask

    // extremes, zero and small values half the time, the rest fully random
    function automatic logic [VALUE_W-1:0] pick_value();
        int s;
        case ($urandom_range(0, 7))
            0: return Q_MOST_NEG;
            1: return Q_MOST_POS;
            2: return '0;
            3:
            begin
                s = $urandom_range(0, 511) - 256;
                return s[VALUE_W-1:0];
            end
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    // chunks whose table entries are known to be written
    function automatic int pick_chunk();
        return $urandom_range(0, 1) ? 0 : NUM_CHUNKS - 1;
    endfunction

    function automatic int pick_cent();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return NUM_CENTROIDS - 1;
            default: return $urandom_range(0, NUM_CENTROIDS - 1);
        endcase
    endfunction

    // write every centroid for the first dims of a chunk; chunk 0 gets
    // extreme centroids at both ends so queries can saturate entries
    task automatic fill_chunk(input int chunk, input int dims);
        logic [VALUE_W-1:0] v;
        for (int d = 0; d < dims; d++)
        begin
            for (int c = 0; c < NUM_CENTROIDS; c++)
            begin
                v = pick_value();
                if (chunk == 0 && c == NUM_CENTROIDS - 1)
                    v = Q_MOST_NEG;
                else if (chunk == 0 && c == 0)
                    v = Q_MOST_POS;
                send_request(REQ_LOAD, chunk, c, d, v, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // one vector of code bytes; a heavy vector hammers the largest of the corner entries
    task automatic run_vector(input int len, input bit heavy);
        int chunk;
        int cent;
        int hot_chunk;
        int hot_cent;
        hot_chunk = 0;
        hot_cent  = 0;
        if (heavy)
        begin
            for (int k = 0; k < 4; k++)
            begin
                chunk = (k < 2) ? 0 : NUM_CHUNKS - 1;
                cent  = (k % 2) ? NUM_CENTROIDS - 1 : 0;
                if (tracker.table_entry(chunk, cent)
                    > tracker.table_entry(hot_chunk, hot_cent))
                begin
                    hot_chunk = chunk;
                    hot_cent  = cent;
                end
            end
        end
        for (int i = 0; i < len; i++)
        begin
            if (heavy)
            begin
                chunk = hot_chunk;
                cent  = hot_cent;
            end
            else if ($urandom_range(0, 15) == 0)
            begin
                // out-of-range chunk adds nothing but can still end a vector
                chunk = $urandom_range(NUM_CHUNKS, 63);
                cent  = $urandom_range(0, NUM_CENTROIDS - 1);
            end
            else
            begin
                chunk = pick_chunk();
                cent  = pick_cent();
            end
            send_request(REQ_CODE, chunk, cent, $urandom_range(0, 15), VALUE_W'($urandom),
                         i == len - 1);
        end
    endtask

    // rebuild table entries: full pass on chunk 0, dim 0 on the top chunk,
    // or a single accumulating dim on chunk 0
    task automatic run_query_pass();
        bit                 same_value;
        logic [VALUE_W-1:0] v;
        same_value = ($urandom_range(0, 3) == 0);
        v = pick_value();
        case ($urandom_range(0, 2))
            0:
            begin
                for (int d = 0; d < SUB_DIM; d++)
                    send_request(REQ_QUERY, 0, $urandom, d, same_value ? v : pick_value(),
                                 1'($urandom_range(0, 1)));
            end
            1: send_request(REQ_QUERY, NUM_CHUNKS - 1, $urandom, 0, v,
                            1'($urandom_range(0, 1)));
            default:
                send_request(REQ_QUERY, 0, $urandom, $urandom_range(1, SUB_DIM - 1), v,
                             1'($urandom_range(0, 1)));
        endcase
    endtask

    // codebook writes anywhere, in range or not
    task automatic run_reloads();
        repeat ($urandom_range(1, 6))
            send_request(REQ_LOAD, $urandom_range(0, 63), $urandom_range(0, 255),
                         $urandom_range(0, 15), pick_value(), 1'($urandom_range(0, 1)));
    endtask

    // requests the block must drop
    task automatic run_noise();
        case ($urandom_range(0, 2))
            0: send_request(REQ_SPARE, $urandom_range(0, 63), $urandom_range(0, 255),
                            $urandom_range(0, 15), VALUE_W'($urandom),
                            1'($urandom_range(0, 1)));
            1: send_request(REQ_QUERY, $urandom_range(NUM_CHUNKS, 63), $urandom_range(0, 255),
                            $urandom_range(0, 15), VALUE_W'($urandom),
                            1'($urandom_range(0, 1)));
            default:
                send_request(REQ_QUERY, pick_chunk(), $urandom_range(0, 255),
                             $urandom_range(SUB_DIM, 15), VALUE_W'($urandom),
                             1'($urandom_range(0, 1)));
        endcase
    endtask

    initial
    begin
        int  start_items;
        int  pick;
        bit  squeeze_done;
        bit  first_seq;
        rst_n                 <= 1'b0;
        req_ch.valid          <= 1'b0;
        req_ch.req_type       <= REQ_LOAD;
        req_ch.chunk_index    <= '0;
        req_ch.centroid_index <= '0;
        req_ch.dim_index      <= '0;
        req_ch.value          <= '0;
        req_ch.last           <= 1'b0;
        real_items   = 0;
        gaps_on      = 1'b1;
        calm         = 1'b0;
        hold_request = 1'b0;
        squeeze_done = 1'b0;
        first_seq    = 1'b1;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // codebook set-up: every query below only reads written centroids
        fill_chunk(0, SUB_DIM);
        fill_chunk(NUM_CHUNKS - 1, 1);

        // directed: dim 0 restarts an entry, then a single code reads it
        send_request(REQ_QUERY, 0, 0, 0, '0, 1'b0);
        send_request(REQ_CODE, 0, NUM_CENTROIDS - 1, 0, '0, 1'b1);
        // extreme query against extreme centroids saturates the entry
        for (int d = 0; d < SUB_DIM; d++)
            send_request(REQ_QUERY, 0, 0, d, Q_MOST_POS, 1'b0);
        // last flag on a query is meaningless
        send_request(REQ_QUERY, NUM_CHUNKS - 1, 0, 0, Q_MOST_NEG, 1'b1);
        send_request(REQ_CODE, 0, NUM_CENTROIDS - 1, 0, '0, 1'b0);
        send_request(REQ_CODE, 0, 0, 0, '0, 1'b0);
        send_request(REQ_CODE, NUM_CHUNKS - 1, NUM_CENTROIDS - 1, 0, '0, 1'b1);
        send_request(REQ_CODE, NUM_CHUNKS - 1, 0, 0, '0, 1'b1);
        // out-of-range code bytes inside a vector and as its last byte
        send_request(REQ_CODE, 0, 1, 0, '0, 1'b0);
        send_request(REQ_CODE, 50, 200, 0, '0, 1'b0);
        send_request(REQ_CODE, 63, NUM_CENTROIDS - 1, 15, '1, 1'b1);
        send_request(REQ_CODE, NUM_CHUNKS, 0, 0, '0, 1'b1);
        // dropped requests: spare type, out-of-range loads and queries, plus one in-range load
        send_request(REQ_SPARE, 0, 0, 0, '0, 1'b1);
        send_request(REQ_LOAD, 60, 3, 2, Q_MOST_POS, 1'b1);
        send_request(REQ_LOAD, 5, 9, 9, Q_MOST_NEG, 1'b0);
        send_request(REQ_LOAD, 3, 7, 1, 16'h1234, 1'b1);
        send_request(REQ_QUERY, 52, 0, 0, Q_MOST_POS, 1'b0);
        send_request(REQ_QUERY, 0, 0, 15, Q_MOST_NEG, 1'b0);

        // random part: mostly code vectors, with table rebuilds, codebook reloads and noise
        start_items = real_items;
        while (real_items - start_items < RANDOM_ITEMS)
        begin
            gaps_on = ($urandom_range(0, 2) != 0);
            if (real_items - start_items >= CALM_AFTER)
                calm = 1'b1;
            if (!squeeze_done && real_items - start_items >= SQUEEZE_AT)
            begin
                // output held off while short vectors keep coming, so the
                // block backs up and stalls its request side
                squeeze_done = 1'b1;
                hold_request = 1'b1;
                gaps_on      = 1'b0;
                wait (!hold_request);
                repeat (40)
                    run_vector(1, 1'b0);
            end
            else if (first_seq)
            begin
                // saturate the accumulator right away
                first_seq = 1'b0;
                run_vector($urandom_range(66, 90), 1'b1);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    run_vector(($urandom_range(0, 7) == 0) ? $urandom_range(9, 20)
                                                          : $urandom_range(1, 8), 1'b0);
                else if (pick < 62)
                    run_query_pass();
                else if (pick < 74)
                    run_reloads();
                else if (pick < 84)
                    run_noise();
                else if (pick < 88)
                    run_vector($urandom_range(66, 90), 1'b1);
                else
                begin
                    // vector broken up by table or codebook changes
                    repeat ($urandom_range(1, 4))
                        send_request(REQ_CODE, pick_chunk(), pick_cent(), 0,
                                     VALUE_W'($urandom), 1'b0);
                    if ($urandom_range(0, 1))
                        run_query_pass();
                    else
                        run_reloads();
                    run_vector($urandom_range(1, 6), 1'b0);
                end
            end
        end
        req_ch.valid <= 1'b0;

        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("** pq_adc_distance_core: PASSED **");
        else
            $display("** pq_adc_distance_core: FAILED **");
        $finish;
    end

endmodule
